@@ sv/elastic_collision_resolve_2d_core_assert.svh @@
// assertion macros for the elastic collision core
// expects aclk and aresetn in the scope where a macro is used
`ifndef ELASTIC_COLLISION_RESOLVE_2D_CORE_ASSERT_SVH
`define ELASTIC_COLLISION_RESOLVE_2D_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ECR_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ecr: implication check failed");
`define ECR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ecr: next-cycle check failed");
`else
`define ECR_ASSERT_IMPLY(lbl, ante, cons)
`define ECR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/ecr_pkg.sv @@
// shared widths, context type and saturation helpers for the collision core
// no dependencies
package ecr_pkg;

    localparam int POS_WIDTH = 24;
    localparam int VEL_WIDTH = 16;
    localparam int RAD_WIDTH = 16;
    localparam int SUM_W     = RAD_WIDTH + 1;
    // pairs further apart than 2^17 on either axis never overlap
    localparam int DIFF_W    = 18;
    localparam int D2_W      = 2 * DIFF_W;
    localparam int K_W       = 2 * DIFF_W;
    localparam int ROOT_W    = D2_W / 2;
    localparam int OV_W      = ROOT_W + 1;
    localparam int OX_W      = OV_W + DIFF_W;
    localparam int DIV_Q_W   = 18;
    localparam int DIV_DEN_W = D2_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = DIV_Q_W + 1;
    localparam int PIPE_DEPTH = 4 + SQRT_LAT + 2 + DIV_LAT + 1;
    localparam int IN_DATA_W  = 4 * POS_WIDTH + 4 * VEL_WIDTH + 2 * RAD_WIDTH;
    localparam int OUT_DATA_W = 4 * POS_WIDTH + 4 * VEL_WIDTH;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] x1;
        logic signed [POS_WIDTH-1:0] y1;
        logic signed [POS_WIDTH-1:0] x2;
        logic signed [POS_WIDTH-1:0] y2;
        logic signed [VEL_WIDTH-1:0] v1x;
        logic signed [VEL_WIDTH-1:0] v1y;
        logic signed [VEL_WIDTH-1:0] v2x;
        logic signed [VEL_WIDTH-1:0] v2y;
        logic [SUM_W-1:0]            sum;
        logic                        hit;
        logic signed [DIFF_W-1:0]    dx;
        logic signed [DIFF_W-1:0]    dy;
        logic signed [K_W-1:0]       k;
        logic [D2_W-1:0]             d2;
    } ctx_t;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(
        input logic signed [POS_WIDTH+1:0] v);
        logic [2:0] top;
        top = v[POS_WIDTH+1:POS_WIDTH-1];
        if (top == 3'b000 || top == 3'b111)
            return v[POS_WIDTH-1:0];
        else if (v[POS_WIDTH+1])
            return {1'b1, {(POS_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(POS_WIDTH-1){1'b1}}};
    endfunction

    function automatic logic signed [VEL_WIDTH-1:0] sat_vel(
        input logic signed [VEL_WIDTH+3:0] v);
        logic [4:0] top;
        top = v[VEL_WIDTH+3:VEL_WIDTH-1];
        if (top == 5'b00000 || top == 5'b11111)
            return v[VEL_WIDTH-1:0];
        else if (v[VEL_WIDTH+3])
            return {1'b1, {(VEL_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(VEL_WIDTH-1){1'b1}}};
    endfunction

endpackage

@@ sv/ecr_sqrt.sv @@
// pipelined integer square root, one result bit per stage
// depends on ecr_pkg
module ecr_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [ecr_pkg::D2_W-1:0]      d2,
    output logic [ecr_pkg::ROOT_W-1:0]    root
);
    localparam int N = ecr_pkg::ROOT_W;
    localparam int W = ecr_pkg::D2_W;

    logic [W-1:0] v_reg [N];
    logic [W-1:0] r_reg [N];
    logic [W-1:0] v_next [N];
    logic [W-1:0] r_next [N];
    logic [W-1:0] v_in [N];
    logic [W-1:0] r_in [N];
    logic [W-1:0] bit_c [N];
    logic [W:0]   trial [N];

    always_comb begin
        for (int j = 0; j < N; j++) begin
            v_in[j]  = (j == 0) ? d2 : v_reg[(j == 0) ? 0 : j - 1];
            r_in[j]  = (j == 0) ? '0 : r_reg[(j == 0) ? 0 : j - 1];
            bit_c[j] = W'(1) << (2 * (N - 1 - j));
            trial[j] = {1'b0, r_in[j]} + {1'b0, bit_c[j]};
            if ({1'b0, v_in[j]} >= trial[j]) begin
                v_next[j] = v_in[j] - trial[j][W-1:0];
                r_next[j] = (r_in[j] >> 1) + bit_c[j];
            end else begin
                v_next[j] = v_in[j];
                r_next[j] = r_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < N; j++) begin
                v_reg[j] <= v_next[j];
                r_reg[j] <= r_next[j];
            end
        end
    end

    assign root = r_reg[N-1][N-1:0];

endmodule

@@ sv/ecr_div.sv @@
// pipelined rounding divider, halves away from zero, one quotient bit per stage
// depends on ecr_pkg
module ecr_div (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [ecr_pkg::DIV_NUM_W-1:0] num,
    input  logic [ecr_pkg::DIV_DEN_W-1:0]        den,
    output logic signed [ecr_pkg::DIV_Q_W:0]     quo
);
    localparam int NW = ecr_pkg::DIV_NUM_W;
    localparam int DW = ecr_pkg::DIV_DEN_W;
    localparam int QW = ecr_pkg::DIV_Q_W;
    localparam int NS = QW + 1;

    logic [DW-1:0] rem_reg [NS];
    logic [QW-1:0] lo_reg  [NS];
    logic [QW-1:0] q_reg   [NS];
    logic [DW-1:0] den_reg [NS];
    logic          neg_reg [NS];
    logic [DW-1:0] rem_next [NS];
    logic [QW-1:0] lo_next  [NS];
    logic [QW-1:0] q_next   [NS];
    logic [DW-1:0] den_next [NS];
    logic          neg_next [NS];
    logic [DW:0]   trial [QW];
    logic [NW-1:0] mag;
    logic [NW-1:0] rnd;

    always_comb begin
        // magnitude plus half the divisor, then plain long division
        mag = num[NW-1] ? NW'(-num) : NW'(num);
        rnd = mag + NW'(den >> 1);
        rem_next[0] = rnd[NW-1:QW];
        lo_next[0]  = rnd[QW-1:0];
        q_next[0]   = '0;
        den_next[0] = den;
        neg_next[0] = num[NW-1];
        for (int j = 1; j < NS; j++) begin
            trial[j-1]  = {rem_reg[j-1], lo_reg[j-1][QW-1]};
            lo_next[j]  = lo_reg[j-1] << 1;
            den_next[j] = den_reg[j-1];
            neg_next[j] = neg_reg[j-1];
            if (trial[j-1] >= {1'b0, den_reg[j-1]}) begin
                rem_next[j] = DW'(trial[j-1] - {1'b0, den_reg[j-1]});
                q_next[j]   = {q_reg[j-1][QW-2:0], 1'b1};
            end else begin
                rem_next[j] = trial[j-1][DW-1:0];
                q_next[j]   = {q_reg[j-1][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NS; j++) begin
                rem_reg[j] <= rem_next[j];
                lo_reg[j]  <= lo_next[j];
                q_reg[j]   <= q_next[j];
                den_reg[j] <= den_next[j];
                neg_reg[j] <= neg_next[j];
            end
        end
    end

    assign quo = neg_reg[NS-1] ? -$signed({1'b0, q_reg[NS-1]}) : $signed({1'b0, q_reg[NS-1]});

endmodule

@@ sv/elastic_collision_resolve_2d_core.sv @@
// top level of the equal-mass elastic collision core for two circular particles
// depends on ecr_pkg, ecr_sqrt, ecr_div and elastic_collision_resolve_2d_core_assert.svh
//
// usage
// - one particle pair enters per item on the s_ channel, one resolved pair leaves
//   per item on the m_ channel, in the same order
// - if the centres overlap (distance nonzero and below the radius sum) the normal
//   velocity components are swapped and both particles are pushed apart by half
//   the overlap; otherwise the item passes through with m_tuser low
// - the long part of the pipeline is the 18-stage square root followed by the
//   19-stage rounding dividers
// - throughput is one item per cycle while the output is not stalled: every
//   stage is a register and the whole pipeline moves on a single enable
// - when the receiver holds m_tready low with a result waiting, the pipeline
//   freezes and s_tready drops; bubbles in between are kept, nothing is lost
// - reset (aresetn low, synchronous) clears all valid bits; data stages keep
//   whatever they held
`include "elastic_collision_resolve_2d_core_assert.svh"
module elastic_collision_resolve_2d_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_radius,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_radius
    input  logic [ecr_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
    // new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y
    output logic [ecr_pkg::OUT_DATA_W-1:0]     m_tdata,
    // collided
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready
);
    localparam int PW = ecr_pkg::POS_WIDTH;
    localparam int VW = ecr_pkg::VEL_WIDTH;
    localparam int RW = ecr_pkg::RAD_WIDTH;
    localparam int ST4 = 3;
    localparam int ST5 = 4 + ecr_pkg::SQRT_LAT;

    // pipeline enable: moves whenever the output slot is free or being taken
    logic en;
    logic [ecr_pkg::PIPE_DEPTH-1:0] vld_reg;

    // stage 1: raw differences
    ecr_pkg::ctx_t c1_reg, c1_next;
    logic signed [PW:0] dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic signed [VW:0] dvx1_reg, dvy1_reg, dvx1_next, dvy1_next;
    // stage 2: squares and velocity projections
    ecr_pkg::ctx_t c2_reg, c2_next;
    logic far2_reg, far2_next;
    logic near_x, near_y;
    logic signed [ecr_pkg::D2_W-1:0]  dxx2_reg, dyy2_reg, dxx2_next, dyy2_next;
    logic signed [ecr_pkg::K_W-2:0]   kx2_reg, ky2_reg, kx2_next, ky2_next;
    // stage 3: squared distance, dot product, squared radius sum
    ecr_pkg::ctx_t c3_reg, c3_next;
    logic far3_reg;
    logic [2*ecr_pkg::SUM_W-1:0] ss3_reg, ss3_next;
    // stage 4: overlap decision
    ecr_pkg::ctx_t c4_reg, c4_next;
    // square root and its context line
    ecr_pkg::ctx_t cq_reg [ecr_pkg::SQRT_LAT];
    logic [ecr_pkg::ROOT_W-1:0] root;
    // stage 5: overlap depth and push divisor
    ecr_pkg::ctx_t c5_reg;
    logic signed [ecr_pkg::OV_W-1:0] ov5_reg, ov5_next;
    logic [ecr_pkg::ROOT_W:0]        den5_reg, den5_next;
    // stage 6: dividends
    ecr_pkg::ctx_t c6_reg;
    logic signed [ecr_pkg::DIV_NUM_W-1:0] nkx6_reg, nky6_reg, nkx6_next, nky6_next;
    logic signed [ecr_pkg::OX_W-1:0]      nox6_reg, noy6_reg, nox6_next, noy6_next;
    logic [ecr_pkg::ROOT_W:0]             den6_reg;
    // dividers and their context line
    ecr_pkg::ctx_t cd_reg [ecr_pkg::DIV_LAT];
    logic signed [ecr_pkg::DIV_Q_W:0] tx, ty, px, py;
    logic signed [ecr_pkg::DIV_Q_W:0] tx_sel, ty_sel, px_sel, py_sel;
    ecr_pkg::ctx_t cf;
    // output register
    logic [ecr_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg;

    assign en       = !vld_reg[ecr_pkg::PIPE_DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[ecr_pkg::PIPE_DEPTH-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ecr_pkg::PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // unpack and take differences
    always_comb begin
        c1_next     = '0;
        c1_next.x1  = s_tdata[0*PW +: PW];
        c1_next.y1  = s_tdata[1*PW +: PW];
        c1_next.v1x = s_tdata[2*PW +: VW];
        c1_next.v1y = s_tdata[2*PW+VW +: VW];
        c1_next.x2  = s_tdata[2*PW+2*VW+RW +: PW];
        c1_next.y2  = s_tdata[3*PW+2*VW+RW +: PW];
        c1_next.v2x = s_tdata[4*PW+2*VW+RW +: VW];
        c1_next.v2y = s_tdata[4*PW+3*VW+RW +: VW];
        c1_next.sum = ecr_pkg::SUM_W'(s_tdata[2*PW+2*VW +: RW])
                    + ecr_pkg::SUM_W'(s_tdata[4*PW+4*VW+RW +: RW]);
        dx1_next    = c1_next.x2 - c1_next.x1;
        dy1_next    = c1_next.y2 - c1_next.y1;
        dvx1_next   = c1_next.v2x - c1_next.v1x;
        dvy1_next   = c1_next.v2y - c1_next.v1y;
    end

    // far pairs are flagged and their differences narrowed
    always_comb begin
        near_x = (dx1_reg[PW:ecr_pkg::DIFF_W-1] == '0 || dx1_reg[PW:ecr_pkg::DIFF_W-1] == '1)
              && dx1_reg[ecr_pkg::DIFF_W-1:0] != {1'b1, {(ecr_pkg::DIFF_W-1){1'b0}}};
        near_y = (dy1_reg[PW:ecr_pkg::DIFF_W-1] == '0 || dy1_reg[PW:ecr_pkg::DIFF_W-1] == '1)
              && dy1_reg[ecr_pkg::DIFF_W-1:0] != {1'b1, {(ecr_pkg::DIFF_W-1){1'b0}}};
        far2_next  = !(near_x && near_y);
        c2_next    = c1_reg;
        c2_next.dx = dx1_reg[ecr_pkg::DIFF_W-1:0];
        c2_next.dy = dy1_reg[ecr_pkg::DIFF_W-1:0];
        dxx2_next  = c2_next.dx * c2_next.dx;
        dyy2_next  = c2_next.dy * c2_next.dy;
        kx2_next   = dvx1_reg * c2_next.dx;
        ky2_next   = dvy1_reg * c2_next.dy;
    end

    always_comb begin
        c3_next    = c2_reg;
        c3_next.d2 = $unsigned(dxx2_reg) + $unsigned(dyy2_reg);
        c3_next.k  = ecr_pkg::K_W'(kx2_reg) + ecr_pkg::K_W'(ky2_reg);
        ss3_next   = c2_reg.sum * c2_reg.sum;
        c4_next     = c3_reg;
        c4_next.hit = !far3_reg && c3_reg.d2 != '0 && c3_reg.d2 < ecr_pkg::D2_W'(ss3_reg);
    end

    ecr_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .d2   (c4_reg.d2),
        .root (root)
    );

    // overlap depth; the push is divided by twice the distance
    always_comb begin
        ov5_next  = $signed({2'b00, cq_reg[ecr_pkg::SQRT_LAT-1].sum}) - $signed({1'b0, root});
        den5_next = {root, 1'b0};
        nkx6_next = c5_reg.k * c5_reg.dx;
        nky6_next = c5_reg.k * c5_reg.dy;
        nox6_next = ov5_reg * c5_reg.dx;
        noy6_next = ov5_reg * c5_reg.dy;
    end

    ecr_div u_div_tx (.aclk(aclk), .en(en), .num(nkx6_reg), .den(c6_reg.d2), .quo(tx));
    ecr_div u_div_ty (.aclk(aclk), .en(en), .num(nky6_reg), .den(c6_reg.d2), .quo(ty));
    ecr_div u_div_px (.aclk(aclk), .en(en), .num(ecr_pkg::DIV_NUM_W'(nox6_reg)),
                      .den(ecr_pkg::DIV_DEN_W'(den6_reg)), .quo(px));
    ecr_div u_div_py (.aclk(aclk), .en(en), .num(ecr_pkg::DIV_NUM_W'(noy6_reg)),
                      .den(ecr_pkg::DIV_DEN_W'(den6_reg)), .quo(py));

    // apply corrections only on a hit, then saturate
    always_comb begin
        cf     = cd_reg[ecr_pkg::DIV_LAT-1];
        tx_sel = cf.hit ? tx : '0;
        ty_sel = cf.hit ? ty : '0;
        px_sel = cf.hit ? px : '0;
        py_sel = cf.hit ? py : '0;
        m_tdata_next = {
            ecr_pkg::sat_vel((VW+4)'(cf.v2y) - (VW+4)'(ty_sel)),
            ecr_pkg::sat_vel((VW+4)'(cf.v2x) - (VW+4)'(tx_sel)),
            ecr_pkg::sat_pos((PW+2)'(cf.y2) + (PW+2)'(py_sel)),
            ecr_pkg::sat_pos((PW+2)'(cf.x2) + (PW+2)'(px_sel)),
            ecr_pkg::sat_vel((VW+4)'(cf.v1y) + (VW+4)'(ty_sel)),
            ecr_pkg::sat_vel((VW+4)'(cf.v1x) + (VW+4)'(tx_sel)),
            ecr_pkg::sat_pos((PW+2)'(cf.y1) - (PW+2)'(py_sel)),
            ecr_pkg::sat_pos((PW+2)'(cf.x1) - (PW+2)'(px_sel))
        };
    end

    // data stages, no reset
    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= c1_next;
            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            dvx1_reg <= dvx1_next;
            dvy1_reg <= dvy1_next;
            c2_reg   <= c2_next;
            far2_reg <= far2_next;
            dxx2_reg <= dxx2_next;
            dyy2_reg <= dyy2_next;
            kx2_reg  <= kx2_next;
            ky2_reg  <= ky2_next;
            c3_reg   <= c3_next;
            far3_reg <= far2_reg;
            ss3_reg  <= ss3_next;
            c4_reg   <= c4_next;
            cq_reg[0] <= c4_reg;
            for (int j = 1; j < ecr_pkg::SQRT_LAT; j++)
                cq_reg[j] <= cq_reg[j-1];
            c5_reg   <= cq_reg[ecr_pkg::SQRT_LAT-1];
            ov5_reg  <= ov5_next;
            den5_reg <= den5_next;
            c6_reg   <= c5_reg;
            nkx6_reg <= nkx6_next;
            nky6_reg <= nky6_next;
            nox6_reg <= nox6_next;
            noy6_reg <= noy6_next;
            den6_reg <= den5_reg;
            cd_reg[0] <= c6_reg;
            for (int j = 1; j < ecr_pkg::DIV_LAT; j++)
                cd_reg[j] <= cd_reg[j-1];
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= cf.hit;
        end
    end

    // a hit always has a nonzero distance and a nonzero radius sum
    `ECR_ASSERT_IMPLY(a_hit_has_distance, vld_reg[ST4] && c4_reg.hit, c4_reg.d2 != '0 && c4_reg.sum != '0)
    // after the root, a hit has a positive overlap and a nonzero divisor
    `ECR_ASSERT_IMPLY(a_hit_overlap_positive, vld_reg[ST5] && c5_reg.hit, ov5_reg > 0 && den5_reg != '0)
    // a held result keeps its collided flag while the receiver stalls
    `ECR_ASSERT_NEXT(a_stall_keeps_flag, m_tvalid && !m_tready, m_tuser == $past(m_tuser))

endmodule
